// File: rtl/core/urh_pkg.sv
// ----------------------------------------------------------------------------
// urh_pkg
// Shared types and constants of the undo/redo history ring.
// ----------------------------------------------------------------------------
package urh_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned CAP_W  = 10;
  localparam int unsigned CNT_W  = 10;
  localparam int unsigned POS_W  = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT    = 3'd0,
    CMD_PUSH    = 3'd1,
    CMD_BACK    = 3'd2,
    CMD_FORWARD = 3'd3,
    CMD_READ    = 3'd4
  } cmd_t;

  typedef struct packed {
    logic             ok;
    logic             bypass;
    logic             empty;
    logic             can_undo;
    logic             can_redo;
    logic [CNT_W-1:0] count;
    logic [POS_W-1:0] pos;
  } meta_t;

endpackage

// File: rtl/core/urh_mem.sv
// ----------------------------------------------------------------------------
// urh_mem
// Snapshot ring storage, one shared address port for writes and registered reads.
// ----------------------------------------------------------------------------
module urh_mem
  import urh_pkg::*;
#(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned PTR_W = 9
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic              rd_en,
  input  logic [PTR_W-1:0]  addr,
  input  logic [DATA_W-1:0] wr_data,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] ring_mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= ring_mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/urh_ctrl.sv
// ----------------------------------------------------------------------------
// urh_ctrl
// History pointers, capacity register and per-command next-state logic.
// ----------------------------------------------------------------------------
module urh_ctrl
  import urh_pkg::*;
#(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned PTR_W = 9,
  parameter int unsigned LEN_W = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CAP_W-1:0]  cfg_wr_data,
  input  logic              accept,
  input  logic [CMD_W-1:0]  cmd_in,
  input  logic [DATA_W-1:0] snap_in,
  output logic              mem_wr_en,
  output logic [PTR_W-1:0]  mem_addr,
  output meta_t             meta,
  output logic [DATA_W-1:0] snap
);

  localparam int unsigned SUM_W = PTR_W + 1;
  localparam int unsigned CMP_W = ((CAP_W > LEN_W) ? CAP_W : LEN_W) + 1;

  logic [CAP_W-1:0]  capacity_r;
  logic [LEN_W-1:0]  cap_r, cap_nxt;
  logic [PTR_W-1:0]  oldest_r, oldest_nxt;
  logic [LEN_W-1:0]  length_r, length_nxt;
  logic [PTR_W-1:0]  cursor_r, cursor_nxt;
  meta_t             meta_r, meta_nxt;
  logic [DATA_W-1:0] snap_r;

  cmd_t              cmd;
  logic              ok;
  logic              wr;
  logic [LEN_W-1:0]  cur_inc;
  logic [LEN_W-1:0]  len_trim;
  logic [CMP_W-1:0]  cap_wide;
  logic [LEN_W-1:0]  cap_sel;
  logic [SUM_W-1:0]  oldest_inc;
  logic [PTR_W-1:0]  oldest_wrap;
  logic              empty_nxt;

  function automatic logic [PTR_W-1:0] phys_of(input logic [PTR_W-1:0] base,
                                                input logic [PTR_W-1:0] rel,
                                                input logic [LEN_W-1:0] cap);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, base} + {1'b0, rel};
    if (sum >= SUM_W'(cap)) begin
      sum = sum - SUM_W'(cap);
    end
    return sum[PTR_W-1:0];
  endfunction

  assign cmd         = cmd_t'(cmd_in);
  assign cur_inc     = LEN_W'(cursor_r) + LEN_W'(1);
  assign len_trim    = (cur_inc < length_r) ? cur_inc : length_r;
  assign cap_wide    = CMP_W'(capacity_r);
  assign cap_sel     = (cap_wide == '0 || cap_wide > CMP_W'(DEPTH)) ?
                       LEN_W'(DEPTH) : LEN_W'(cap_wide);
  assign oldest_inc  = {1'b0, oldest_r} + SUM_W'(1);
  assign oldest_wrap = (oldest_inc >= SUM_W'(cap_r)) ? '0 : oldest_inc[PTR_W-1:0];

  always_comb begin
    cap_nxt    = cap_r;
    oldest_nxt = oldest_r;
    length_nxt = length_r;
    cursor_nxt = cursor_r;
    ok         = 1'b0;
    wr         = 1'b0;
    unique case (cmd)
      CMD_INIT: begin
        cap_nxt    = cap_sel;
        oldest_nxt = '0;
        length_nxt = LEN_W'(1);
        cursor_nxt = '0;
        ok         = 1'b1;
        wr         = 1'b1;
      end
      CMD_PUSH: begin
        if (length_r != '0) begin
          ok = 1'b1;
          wr = 1'b1;
          if (len_trim < cap_r) begin
            length_nxt = len_trim + LEN_W'(1);
            cursor_nxt = PTR_W'(len_trim);
          end else begin
            oldest_nxt = oldest_wrap;
            length_nxt = len_trim;
            cursor_nxt = PTR_W'(len_trim - LEN_W'(1));
          end
        end
      end
      CMD_BACK: begin
        if (length_r != '0 && cursor_r != '0) begin
          cursor_nxt = cursor_r - PTR_W'(1);
          ok         = 1'b1;
        end
      end
      CMD_FORWARD: begin
        if (length_r != '0 && cur_inc < length_r) begin
          cursor_nxt = cursor_r + PTR_W'(1);
          ok         = 1'b1;
        end
      end
      CMD_READ: begin
        ok = (length_r != '0);
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // write and read share one address: the slot at the new cursor
  assign mem_addr  = phys_of(oldest_nxt, cursor_nxt, cap_nxt);
  assign mem_wr_en = accept & wr;

  assign empty_nxt = (length_nxt == '0);

  always_comb begin
    meta_nxt.ok       = ok;
    meta_nxt.bypass   = wr;
    meta_nxt.empty    = empty_nxt;
    meta_nxt.can_undo = !empty_nxt && (cursor_nxt != '0);
    meta_nxt.can_redo = !empty_nxt && ((LEN_W'(cursor_nxt) + LEN_W'(1)) < length_nxt);
    meta_nxt.count    = CNT_W'(length_nxt);
    meta_nxt.pos      = POS_W'(cursor_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= '0;
    end else if (cfg_wr_en) begin
      capacity_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= LEN_W'(DEPTH);
      oldest_r <= '0;
      length_r <= '0;
      cursor_r <= '0;
    end else if (accept) begin
      cap_r    <= cap_nxt;
      oldest_r <= oldest_nxt;
      length_r <= length_nxt;
      cursor_r <= cursor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      meta_r <= meta_nxt;
      snap_r <= snap_in;
    end
  end

  assign meta = meta_r;
  assign snap = snap_r;

endmodule

// File: rtl/core/urh_out.sv
// ----------------------------------------------------------------------------
// urh_out
// Result register: picks the current entry and holds the result for the sink.
// ----------------------------------------------------------------------------
module urh_out
  import urh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              stage_valid,
  input  meta_t             stage_meta,
  input  logic [DATA_W-1:0] stage_snap,
  input  logic [DATA_W-1:0] stage_rd_data,
  output logic              load,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_ok,
  output logic [DATA_W-1:0] out_current_entry,
  output logic              out_can_undo,
  output logic              out_can_redo,
  output logic [CNT_W-1:0]  out_entry_count,
  output logic [POS_W-1:0]  out_cursor_pos
);

  logic              out_valid_r;
  logic              ok_r;
  logic [DATA_W-1:0] entry_r;
  logic              can_undo_r;
  logic              can_redo_r;
  logic [CNT_W-1:0]  count_r;
  logic [POS_W-1:0]  pos_r;
  logic [DATA_W-1:0] entry_sel;

  assign load = stage_valid && (!out_valid_r || out_ready);

  // freshly written slot comes from the snapshot, not the ram
  assign entry_sel = stage_meta.empty  ? '0 :
                     stage_meta.bypass ? stage_snap : stage_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ok_r       <= stage_meta.ok;
      entry_r    <= entry_sel;
      can_undo_r <= stage_meta.can_undo;
      can_redo_r <= stage_meta.can_redo;
      count_r    <= stage_meta.count;
      pos_r      <= stage_meta.pos;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ok            = ok_r;
  assign out_current_entry = entry_r;
  assign out_can_undo      = can_undo_r;
  assign out_can_redo      = can_redo_r;
  assign out_entry_count   = count_r;
  assign out_cursor_pos    = pos_r;

endmodule

// File: rtl/core/undo_redo_history_ring_core.sv
// ----------------------------------------------------------------------------
// undo_redo_history_ring_core
// Undo/redo history kept in a ring of snapshot words.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one command with a snapshot word per
// transfer: init, push, back, forward or read current. Result channel
// (out_valid/out_ready): exactly one result per command, in order, with the
// success flag, the entry at the cursor, undo/redo flags, count and cursor.
// Configuration: cfg_wr_en/cfg_wr_data write the ring capacity (0 = DEPTH),
// taken into use at the next init; write it only while the block is idle.
// Each command passes through the pointer update plus ring ram access, then
// the result register. One command is taken every cycle while the sink
// keeps up; the single-port ring access per command sets that rate.
// When the sink stalls, one more command is held in the ram stage, then
// in_ready drops until the result register drains.
// Synchronous reset empties the history (count 0, cursor 0, capacity
// register 0); the ram contents are left as they are and need no clearing.
// ----------------------------------------------------------------------------
module undo_redo_history_ring_core
  import urh_pkg::*;
#(
  parameter int unsigned DEPTH = 512
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CAP_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [DATA_W-1:0] in_snapshot,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_ok,
  output logic [DATA_W-1:0] out_current_entry,
  output logic              out_can_undo,
  output logic              out_can_redo,
  output logic [CNT_W-1:0]  out_entry_count,
  output logic [POS_W-1:0]  out_cursor_pos
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned LEN_W = $clog2(DEPTH + 1);

  logic              accept;
  logic              load;
  logic              stage_valid_r;
  logic              mem_wr_en;
  logic [PTR_W-1:0]  mem_addr;
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] stage_snap;
  meta_t             stage_meta;

  assign in_ready = !stage_valid_r || load;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (accept) begin
      stage_valid_r <= 1'b1;
    end else if (load) begin
      stage_valid_r <= 1'b0;
    end
  end

  urh_ctrl #(
    .DEPTH (DEPTH),
    .PTR_W (PTR_W),
    .LEN_W (LEN_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .cmd_in      (in_cmd),
    .snap_in     (in_snapshot),
    .mem_wr_en   (mem_wr_en),
    .mem_addr    (mem_addr),
    .meta        (stage_meta),
    .snap        (stage_snap)
  );

  urh_mem #(
    .DEPTH (DEPTH),
    .PTR_W (PTR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .rd_en   (accept),
    .addr    (mem_addr),
    .wr_data (in_snapshot),
    .rd_data (rd_data)
  );

  urh_out u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .stage_valid       (stage_valid_r),
    .stage_meta        (stage_meta),
    .stage_snap        (stage_snap),
    .stage_rd_data     (rd_data),
    .load              (load),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_ok            (out_ok),
    .out_current_entry (out_current_entry),
    .out_can_undo      (out_can_undo),
    .out_can_redo      (out_can_redo),
    .out_entry_count   (out_entry_count),
    .out_cursor_pos    (out_cursor_pos)
  );

`ifndef SYNTHESIS
  a_init_always_ok: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_cmd == CMD_INIT |=> stage_valid_r && stage_meta.ok && stage_meta.bypass)
    else $error("init transfer did not produce a successful written result");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> stage_valid_r && out_valid && !out_ready)
    else $error("input stalled while the pipeline had room");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stage_valid_r && !load |=> stage_valid_r && $stable(stage_meta))
    else $error("ram stage lost or changed a pending result");
`endif

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the undo/redo history ring core.
// Commands go in over a valid/ready channel and are mirrored into a local
// history model that tracks ring slots, count and cursor. Each result is
// compared field by field with the oldest predicted view. Directed checks
// cover the empty history, bounds and eviction. Random phases sweep the ring
// capacity, wrap the full depth and run a steady stream. A long output stall
// fills the core so that it stops taking input. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import urh_pkg::*;

  localparam int unsigned RING_DEPTH  = 512;
  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned IDLE_PCT    = 27;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

  typedef struct packed {
    logic             ok;
    logic [DATA_W-1:0] entry;
    logic             can_undo;
    logic             can_redo;
    logic [CNT_W-1:0] count;
    logic [POS_W-1:0] pos;
  } hist_view_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]  cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CMD_W-1:0]  in_cmd = '0;
  logic [DATA_W-1:0] in_snapshot = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_ok;
  logic [DATA_W-1:0] out_current_entry;
  logic              out_can_undo;
  logic              out_can_redo;
  logic [CNT_W-1:0]  out_entry_count;
  logic [POS_W-1:0]  out_cursor_pos;

  // history model
  logic [DATA_W-1:0] ring_mem [RING_DEPTH];
  int unsigned head_slot = 0;
  int unsigned hist_len = 0;
  int unsigned cur_pos = 0;
  int unsigned ring_size = RING_DEPTH;
  int unsigned cap_reg = 0;

  hist_view_t  pending_views[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sink_hold = 0;
  bit          sender_steady = 1'b0;
  bit          sink_steady = 1'b0;

  undo_redo_history_ring_core #(
    .DEPTH(RING_DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_snapshot      (in_snapshot),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_ok           (out_ok),
    .out_current_entry(out_current_entry),
    .out_can_undo     (out_can_undo),
    .out_can_redo     (out_can_redo),
    .out_entry_count  (out_entry_count),
    .out_cursor_pos   (out_cursor_pos)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int unsigned ring_slot(input int unsigned rel);
    int unsigned p;
    p = head_slot + rel;
    if (p >= ring_size) p -= ring_size;
    return p % RING_DEPTH;
  endfunction

  function automatic hist_view_t apply_history_cmd(input logic [CMD_W-1:0] c,
                                                   input logic [DATA_W-1:0] s);
    hist_view_t v;
    v = '0;
    case (c)
      CMD_INIT: begin
        ring_size = (cap_reg == 0 || cap_reg > RING_DEPTH) ? RING_DEPTH : cap_reg;
        head_slot = 0;
        ring_mem[0] = s;
        hist_len = 1;
        cur_pos = 0;
        v.ok = 1'b1;
      end
      CMD_PUSH: begin
        if (hist_len != 0) begin
          // redo entries beyond the cursor are dropped first
          if (cur_pos + 1 < hist_len) hist_len = cur_pos + 1;
          if (hist_len < ring_size) begin
            ring_mem[ring_slot(hist_len)] = s;
            hist_len++;
          end else begin
            head_slot++;
            if (head_slot >= ring_size) head_slot = 0;
            ring_mem[ring_slot(hist_len - 1)] = s;
          end
          cur_pos = hist_len - 1;
          v.ok = 1'b1;
        end
      end
      CMD_BACK: begin
        if (hist_len != 0 && cur_pos > 0) begin
          cur_pos--;
          v.ok = 1'b1;
        end
      end
      CMD_FORWARD: begin
        if (hist_len != 0 && cur_pos + 1 < hist_len) begin
          cur_pos++;
          v.ok = 1'b1;
        end
      end
      CMD_READ: begin
        v.ok = (hist_len != 0);
      end
      default: begin
      end
    endcase
    if (hist_len != 0) v.entry = ring_mem[ring_slot(cur_pos)];
    v.can_undo = (hist_len != 0 && cur_pos > 0);
    v.can_redo = (hist_len != 0 && cur_pos + 1 < hist_len);
    v.count = CNT_W'(hist_len);
    v.pos = POS_W'(cur_pos);
    return v;
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd(input int unsigned push_pct);
    int unsigned r;
    if ($urandom_range(99) < push_pct) return CMD_PUSH;
    r = $urandom_range(99);
    if (r < 6) return CMD_INIT;
    if (r < 38) return CMD_BACK;
    if (r < 66) return CMD_FORWARD;
    if (r < 90) return CMD_READ;
    return CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
  endfunction

  task automatic issue_cmd(input logic [CMD_W-1:0] c, input logic [DATA_W-1:0] s);
    while (!sender_steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= c;
    in_snapshot <= s;
    do @(posedge clk); while (!in_ready);
    pending_views.push_back(apply_history_cmd(c, s));
  endtask

  task automatic settle_history();
    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
  endtask

  task automatic set_capacity(input int unsigned cap);
    settle_history();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= CAP_W'(cap);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cap_reg = cap;
  endtask

  // a few commands still on the old ring, then init takes up the new capacity
  task automatic run_phase(input int unsigned cap, input int unsigned n,
                           input int unsigned push_pct);
    set_capacity(cap);
    repeat (4) issue_cmd(pick_cmd(36), $urandom());
    issue_cmd(CMD_INIT, $urandom());
    repeat (n) issue_cmd(pick_cmd(push_pct), $urandom());
  endtask

  task automatic check_field(input string field, input logic [DATA_W-1:0] want_v,
                             input logic [DATA_W-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    hist_view_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_views.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual ok=%0b entry=%0h",
                 $time, out_ok, out_current_entry);
        mismatch_count++;
      end else begin
        want = pending_views.pop_front();
        check_field("ok", want.ok, out_ok);
        check_field("current_entry", want.entry, out_current_entry);
        check_field("can_undo", want.can_undo, out_can_undo);
        check_field("can_redo", want.can_redo, out_can_redo);
        check_field("entry_count", want.count, out_entry_count);
        check_field("cursor_pos", want.pos, out_cursor_pos);
      end
    end
  end

  always @(posedge clk) begin
    if (sink_hold != 0) begin
      out_ready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else if (sink_steady) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // everything but init is refused before the first init
  task automatic test_empty_history();
    issue_cmd(CMD_PUSH, $urandom());
    issue_cmd(CMD_BACK, $urandom());
    issue_cmd(CMD_FORWARD, $urandom());
    issue_cmd(CMD_READ, $urandom());
    issue_cmd(CMD_SPARE_LO, $urandom());
    issue_cmd(CMD_SPARE_MID, $urandom());
    issue_cmd(CMD_SPARE_HI, $urandom());
  endtask

  task automatic test_directed_bounds();
    set_capacity(3);
    issue_cmd(CMD_INIT, '0);
    issue_cmd(CMD_PUSH, '1);
    issue_cmd(CMD_PUSH, 32'h5a5a_0001);
    issue_cmd(CMD_PUSH, 32'h5a5a_0002);
    repeat (3) issue_cmd(CMD_BACK, $urandom());
    repeat (3) issue_cmd(CMD_FORWARD, $urandom());
    issue_cmd(CMD_BACK, $urandom());
    issue_cmd(CMD_PUSH, 32'ha5a5_0003);
    issue_cmd(CMD_READ, $urandom());
    issue_cmd(CMD_INIT, 32'hffff_0000);
  endtask

  task automatic test_capacity_sweep();
    int unsigned caps [7] = '{1, 2, 0, 5, 512, 3, 16};
    foreach (caps[i]) run_phase(caps[i], 15, 36);
  endtask

  // capacity above the depth saturates, so the ring wraps at full depth
  task automatic test_full_depth_wrap();
    run_phase(1023, 560, 98);
  endtask

  task automatic test_steady_stream();
    sender_steady = 1'b1;
    sink_steady = 1'b1;
    run_phase(8, 60, 36);
    sender_steady = 1'b0;
    sink_steady = 1'b0;
  endtask

  task automatic test_output_stall();
    sender_steady = 1'b1;
    sink_hold = 48;
    repeat (16) issue_cmd(pick_cmd(50), $urandom());
    sender_steady = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_history();
    test_directed_bounds();
    test_capacity_sweep();
    test_full_depth_wrap();
    test_steady_stream();
    test_output_stall();
    settle_history();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/urh_pkg.sv
rtl/core/urh_mem.sv
rtl/core/urh_ctrl.sv
rtl/core/urh_out.sv
rtl/core/undo_redo_history_ring_core.sv
tb/sv/tb_top.sv
